// ----- rtl/core/msqd_pkg.sv -----
// Shared types, constants and field layout for the multi-server queue dispatcher.
package msqd_pkg;

  localparam int MAX_SERVERS_DEF = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_SPAN        = 26;
  localparam int LEN_SLOTS       = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SERVER_COUNT = 2'd0,
    CFG_QUEUE_LIMIT  = 2'd1,
    CFG_STOP_TIME    = 2'd2
  } cfg_reg_t;

  localparam logic [2:0]  SERVER_COUNT_RST = 3'd4;
  localparam logic [4:0]  QUEUE_LIMIT_RST  = 5'd16;
  localparam logic [15:0] STOP_TIME_RST    = 16'd0;

  // stream payload widths
  localparam int TICK_W  = 16;
  localparam int LEN_W   = 8;
  localparam int ARR_W   = 4;
  localparam int MASK_W  = 4;
  localparam int CNT4_W  = 4;
  localparam int QCNT_W  = 5;
  localparam int TAG_W   = 5;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 48;

  // result field positions in m_tdata
  localparam int O_TICK  = 0;
  localparam int O_FIN   = 16;
  localparam int O_START = 20;
  localparam int O_BUSY  = 24;
  localparam int O_ACC   = 28;
  localparam int O_REJ   = 32;
  localparam int O_QCNT  = 36;
  localparam int O_HEAD  = 41;
  localparam int O_DONE  = 46;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ARRIVE = 5'b00010,
    S_COMPL  = 5'b00100,
    S_DISP   = 5'b01000,
    S_DONE   = 5'b10000
  } seq_state_t;

endpackage

// ----- rtl/core/multi_server_queue_dispatcher_unit.sv -----
// Multi-server queue dispatcher: one tick per input transfer, one result per tick.
//
// Each input transfer is one simulation tick and yields exactly one result. After the
// transfer the sequencer steps through ARRIVE, COMPL, DISP and DONE; the result is
// loaded into the output register in DONE, held there while the output is stalled,
// and the input is ready again once the sequencer is back in IDLE. The work is done
// by a single 16-bit add/compare unit that the sequencer walks over the servers:
// first the end-time check over every server slot, then dispatch over the servers
// in use.
// Arrivals are admitted in the ARRIVE state. The input is not ready while a tick is in
// work; the output register lets the next tick be taken while a result waits.
// The wait queue holds consecutive tags, so only the head tag and a count are kept.
// Configuration writes are taken at any time but must only be issued while idle.
module multi_server_queue_dispatcher_unit
  import msqd_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // s_tdata: arrival_count[3:0], service_len_0[11:4], service_len_1[19:12],
  //          service_len_2[27:20], service_len_3[35:28], zero fill [39:36]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,
  // m_tdata: tick_now[15:0], finished_mask[19:16], started_mask[23:20],
  //          busy_mask[27:24], accepted[31:28], rejected[35:32],
  //          queue_count[40:36], head_tag[45:41], done_res[46], zero fill [47]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int AW    = (CNT_W > ARR_W) ? CNT_W : ARR_W;

  // configuration
  logic [2:0]        server_count;
  logic [4:0]        queue_limit;
  logic [TICK_W-1:0] stop_time;

  // simulation state
  seq_state_t            state;
  logic [TICK_W-1:0]     tick_counter;
  logic [MAX_SERVERS-1:0] server_busy;
  logic [TICK_W-1:0]     end_time [MAX_SERVERS];
  logic [CNT_W-1:0]      fifo_count;
  logic [TAG_W-1:0]      tag_counter;
  logic [TAG_W-1:0]      head_tag;

  // per-tick work registers
  logic [ARR_W-1:0]      arrivals;
  logic [LEN_W-1:0]      lens [LEN_SLOTS];
  logic [TICK_W-1:0]     tick_cur;
  logic [IDX_W-1:0]      use_last;
  logic [IDX_W-1:0]      srv_idx;
  logic [MAX_SERVERS-1:0] finished;
  logic [MAX_SERVERS-1:0] started;
  logic [CNT4_W-1:0]     acc;
  logic [CNT4_W-1:0]     rej;

  // output register
  logic [OUT_W-1:0]      out_data;
  logic                  out_valid;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= SERVER_COUNT_RST;
      queue_limit  <= QUEUE_LIMIT_RST;
      stop_time    <= STOP_TIME_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SERVER_COUNT: server_count <= cfg_data[2:0];
        CFG_QUEUE_LIMIT:  queue_limit  <= cfg_data[4:0];
        CFG_STOP_TIME:    stop_time    <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared 16-bit add/compare unit
  logic [1:0]        len_slot;
  logic [LEN_W-1:0]  len_eff;
  logic [TICK_W-1:0] op_b;
  logic [TICK_W-1:0] unit_sum;
  logic              unit_eq;

  always_comb begin
    len_slot = 2'(srv_idx);
    len_eff  = (lens[len_slot] == '0) ? LEN_W'(1) : lens[len_slot];
    op_b     = (state == S_COMPL) ? end_time[srv_idx] : TICK_W'(len_eff);
    unit_sum = tick_cur + op_b;
    unit_eq  = (tick_cur == op_b);
  end

  // admission for the ARRIVE step
  logic [AW-1:0]      eff_lim;
  logic [AW-1:0]      cnt_x;
  logic [AW-1:0]      room;
  logic [AW-1:0]      arr_x;
  logic [CNT4_W-1:0]  acc_now;
  logic               admit_open;
  logic [TAG_W:0]     tag_sum;
  logic [TAG_W-1:0]   tag_adv;
  logic [TAG_W-1:0]   head_inc;
  logic [IDX_W-1:0]   use_last_now;

  always_comb begin
    eff_lim = (int'(queue_limit) > QUEUE_DEPTH) ? AW'(QUEUE_DEPTH) : AW'(queue_limit);
    cnt_x   = AW'(fifo_count);
    room    = (cnt_x >= eff_lim) ? '0 : eff_lim - cnt_x;
    arr_x   = AW'(arrivals);
    admit_open = (tick_cur < stop_time);
    acc_now = admit_open ? ((arr_x < room) ? arrivals : CNT4_W'(room)) : '0;
    tag_sum = (TAG_W+1)'(tag_counter) + (TAG_W+1)'(acc_now);
    tag_adv = (tag_sum >= (TAG_W+1)'(TAG_SPAN)) ?
              TAG_W'(tag_sum - (TAG_W+1)'(TAG_SPAN)) : TAG_W'(tag_sum);
    head_inc = (head_tag == TAG_W'(TAG_SPAN - 1)) ? '0 : head_tag + TAG_W'(1);
    if (server_count == 3'd0) begin
      use_last_now = '0;
    end else if (int'(server_count) > MAX_SERVERS) begin
      use_last_now = IDX_W'(MAX_SERVERS - 1);
    end else begin
      use_last_now = IDX_W'(server_count - 3'd1);
    end
  end

  logic out_load;
  logic done_now;
  assign out_load = (state == S_DONE) && (!out_valid || m_tready);
  assign done_now = (tick_cur > stop_time) && (server_busy == '0) && (fifo_count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tick_counter <= '0;
      server_busy  <= '0;
      fifo_count   <= '0;
      tag_counter  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            arrivals <= s_tdata[ARR_W-1:0];
            for (int k = 0; k < LEN_SLOTS; k++) begin
              lens[k] <= s_tdata[ARR_W + k*LEN_W +: LEN_W];
            end
            tick_cur <= tick_counter;
            use_last <= use_last_now;
            state    <= S_ARRIVE;
          end
        end
        S_ARRIVE: begin
          acc <= acc_now;
          rej <= admit_open ? arrivals - acc_now : '0;
          fifo_count  <= fifo_count + CNT_W'(acc_now);
          tag_counter <= tag_adv;
          if (fifo_count == '0 && acc_now != '0) begin
            head_tag <= tag_counter;
          end
          finished <= '0;
          started  <= '0;
          srv_idx  <= '0;
          state    <= S_COMPL;
        end
        S_COMPL: begin
          if (server_busy[srv_idx] && unit_eq) begin
            server_busy[srv_idx] <= 1'b0;
            finished[srv_idx]    <= 1'b1;
          end
          if (srv_idx == IDX_W'(MAX_SERVERS - 1)) begin
            srv_idx <= '0;
            state   <= S_DISP;
          end else begin
            srv_idx <= srv_idx + IDX_W'(1);
          end
        end
        S_DISP: begin
          if (!server_busy[srv_idx] && fifo_count != '0) begin
            end_time[srv_idx]    <= unit_sum;
            server_busy[srv_idx] <= 1'b1;
            started[srv_idx]     <= 1'b1;
            fifo_count           <= fifo_count - CNT_W'(1);
            head_tag             <= head_inc;
          end
          if (srv_idx == use_last) begin
            state <= S_DONE;
          end else begin
            srv_idx <= srv_idx + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (out_load) begin
            tick_counter <= tick_cur + TICK_W'(1);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result word, loaded once per tick
  logic [OUT_W-1:0] out_word;

  always_comb begin
    out_word                      = '0;
    out_word[O_TICK  +: TICK_W]   = tick_cur;
    out_word[O_FIN   +: MASK_W]   = MASK_W'(finished);
    out_word[O_START +: MASK_W]   = MASK_W'(started);
    out_word[O_BUSY  +: MASK_W]   = MASK_W'(server_busy);
    out_word[O_ACC   +: CNT4_W]   = acc;
    out_word[O_REJ   +: CNT4_W]   = rej;
    out_word[O_QCNT  +: QCNT_W]   = QCNT_W'(fifo_count);
    out_word[O_HEAD  +: TAG_W]    = (fifo_count != '0) ? head_tag : '0;
    out_word[O_DONE]              = done_now;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_word;
    end
  end

endmodule

// ----- rtl/core/msqd_checker.sv -----
// Port-level checker for the queue dispatcher, bound to the top level.
module msqd_checker
  import msqd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic [MASK_W-1:0] started_f;
  logic [MASK_W-1:0] busy_f;
  logic [QCNT_W-1:0] qcnt_f;
  logic [TAG_W-1:0]  head_f;
  logic [CNT4_W:0]   arr_sum;

  assign started_f = m_tdata[O_START +: MASK_W];
  assign busy_f    = m_tdata[O_BUSY +: MASK_W];
  assign qcnt_f    = m_tdata[O_QCNT +: QCNT_W];
  assign head_f    = m_tdata[O_HEAD +: TAG_W];
  assign arr_sum   = (CNT4_W+1)'(m_tdata[O_ACC +: CNT4_W]) +
                     (CNT4_W+1)'(m_tdata[O_REJ +: CNT4_W]);

  // a tick in work blocks the input for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_started_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (started_f & ~busy_f) == '0)
    else $error("started server not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[O_DONE] |-> busy_f == '0 && qcnt_f == '0)
    else $error("done with work outstanding");

  a_head_tag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> head_f < TAG_W'(TAG_SPAN) && (qcnt_f != '0 || head_f == '0)
                 && arr_sum <= (CNT4_W+1)'(15))
    else $error("bad head tag or arrival split");

endmodule

bind multi_server_queue_dispatcher_unit msqd_checker u_msqd_checker (.*);
